[rtl/plf_pkg.sv]
// Shared types, constants and helpers for the Playfair stream encryption core.
package plf_pkg;

  // Square geometry and field widths.
  localparam int unsigned SQ_DIM    = 5;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned IDX_W     = $clog2(SQ_DIM);
  localparam int unsigned ROW_W     = SQ_DIM * CODE_W;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [CODE_W-1:0]              letter_t;
  typedef logic [IDX_W-1:0]               sq_idx_t;
  typedef logic [ROW_W-1:0]               key_row_t;
  typedef logic [SQ_DIM-1:0][ROW_W-1:0]   key_sq_t;
  typedef logic [CHAR_W-1:0]              cipher_char_t;

  // Letter codes, a = 0.
  localparam letter_t LETTER_I = letter_t'(8);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_X = letter_t'(23);
  localparam letter_t LETTER_Z = letter_t'(25);

  // ASCII bounds of the two letter ranges.
  localparam logic [BYTE_W-1:0] ASCII_LC_A = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LC_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] ASCII_UC_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UC_Z = 8'h5A;

  // Reset key square: m f h i k / u n o p q / z v w x y / e l a r g / d s t b c.
  localparam key_row_t KEY_ROW_RST [SQ_DIM] = '{
    key_row_t'(10755244), key_row_t'(17283508), key_row_t'(25942713),
    key_row_t'(6848868),  key_row_t'(2149955)
  };

  // Position of a letter in the square.
  typedef struct packed {
    sq_idx_t row;
    sq_idx_t col;
  } sq_pos_t;

  // Two enciphered letters of one digraph.
  typedef struct packed {
    cipher_char_t first;
    cipher_char_t second;
  } pair_chars_t;

  // Letter code to lowercase ASCII, codes above z clamp to z.
  function automatic cipher_char_t to_char(letter_t code);
    letter_t c;
    c = (code > LETTER_Z) ? LETTER_Z : code;
    return cipher_char_t'(ASCII_LC_A) + cipher_char_t'(c);
  endfunction

endpackage

[rtl/plf_if.sv]
// Valid/ready channel interfaces for text input, cipher output and configuration.
interface plf_in_if;
  import plf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    text_byte;
  logic                 message_end;
  modport source (output valid, output text_byte, output message_end, input ready);
  modport sink   (input valid, input text_byte, input message_end, output ready);
endinterface

interface plf_out_if;
  import plf_pkg::*;
  logic                 valid;
  logic                 ready;
  cipher_char_t         cipher_char;
  logic                 run_last;
  logic                 text_done;
  modport source (output valid, output cipher_char, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input cipher_char, input run_last, input text_done,
                  output ready);
endinterface

interface plf_cfg_if;
  import plf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  key_row_t             data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/playfair_stream_encrypt_core.sv]
// Top level of the Playfair stream encryption core.
//
//   Channel  | Direction | Beat payload                          | Handshake
//   in_ch    | sink      | text_byte[7:0], message_end           | valid/ready
//   out_ch   | source    | cipher_char[6:0], run_last, text_done | valid/ready
//   cfg_ch   | sink      | index[2:0] -> key_row_<index>, data   | valid/ready, always ready
//
// A byte is registered on acceptance, then decoded and paired from that register, and its
// beats are loaded into the result buffer. One byte enters per cycle while the result
// buffer keeps pace; a byte that closes a pair loads two or four beats, and the single
// output port then sets the rate at one beat per cycle while out_ch.ready is high.
// Reset (rst_n low, synchronous) loads the default square and clears the held letter.
// Bytes that produce no beats pass through even while the output side stalls.
module playfair_stream_encrypt_core
  import plf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  plf_in_if.sink    in_ch,
  plf_out_if.source out_ch,
  plf_cfg_if.sink   cfg_ch
);

  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned PTR_W     = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);

  typedef struct packed {
    cipher_char_t ch;
    logic         last;
    logic         done;
  } beat_t;

  // Configuration registers.
  key_sq_t key_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_DIM; i++) begin
        key_r[i] <= KEY_ROW_RST[i];
      end
    end else if (cfg_ch.valid && (cfg_ch.index < CFG_IDX_W'(SQ_DIM))) begin
      key_r[cfg_ch.index[IDX_W-1:0]] <= cfg_ch.data;
    end
  end

  // Input register.
  logic              item_v_r;
  logic [BYTE_W-1:0] byte_r;
  logic              end_r;
  logic              fire;

  assign in_ch.ready = !item_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.text_byte;
      end_r  <= in_ch.message_end;
    end
  end

  // Letter decode with upper and lower case folded together and j folded to i.
  logic    is_lower;
  logic    is_upper;
  logic    is_letter;
  letter_t raw_code;
  letter_t code;

  assign is_lower  = (byte_r >= ASCII_LC_A) && (byte_r <= ASCII_LC_Z);
  assign is_upper  = (byte_r >= ASCII_UC_A) && (byte_r <= ASCII_UC_Z);
  assign is_letter = is_lower || is_upper;

  always_comb begin
    if (is_lower) begin
      raw_code = letter_t'(byte_r - ASCII_LC_A);
    end else if (is_upper) begin
      raw_code = letter_t'(byte_r - ASCII_UC_A);
    end else begin
      raw_code = '0;
    end
  end

  assign code = (raw_code == LETTER_J) ? LETTER_I : raw_code;

  // Held letter of an unfinished pair.
  letter_t held_r;
  letter_t held_nxt;
  logic    held_v_r;
  logic    held_v_nxt;

  logic    same;
  logic    pair_en;
  logic    pad_en;
  letter_t pair_b;
  letter_t pad_a;

  assign same    = held_v_r && (held_r == code);
  assign pair_en = is_letter && held_v_r;
  assign pair_b  = same ? LETTER_X : code;
  assign pad_a   = is_letter ? code : held_r;
  assign pad_en  = end_r && (is_letter ? (!held_v_r || same) : held_v_r);

  always_comb begin
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    if (pad_en) begin
      held_nxt   = '0;
      held_v_nxt = 1'b0;
    end else if (is_letter) begin
      if (!held_v_r) begin
        held_nxt   = code;
        held_v_nxt = 1'b1;
      end else if (!same) begin
        held_nxt   = '0;
        held_v_nxt = 1'b0;
      end
    end
  end

  // Two digraph units: the closing pair and the padding pair.
  pair_chars_t pair_chars;
  pair_chars_t pad_chars;

  plf_pair u_pair (
    .key_sq   (key_r),
    .letter_a (held_r),
    .letter_b (pair_b),
    .chars    (pair_chars)
  );

  plf_pair u_pad (
    .key_sq   (key_r),
    .letter_a (pad_a),
    .letter_b (LETTER_X),
    .chars    (pad_chars)
  );

  // Result buffer of up to four beats.
  beat_t            buf_r [BUF_DEPTH];
  logic [PTR_W-1:0] rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_fire;
  logic             buf_free;
  logic [CNT_W-1:0] n_res;
  beat_t            slot [BUF_DEPTH];

  assign out_fire = out_ch.valid && out_ch.ready;
  assign buf_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign n_res    = CNT_W'({pair_en, 1'b0}) + CNT_W'({pad_en, 1'b0});
  assign fire     = item_v_r && ((n_res == '0) || buf_free);

  // Pack the beats of this byte in order, flagging the final one.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      slot[i] = '0;
    end
    if (pair_en) begin
      slot[0].ch = pair_chars.first;
      slot[1].ch = pair_chars.second;
      slot[2].ch = pad_chars.first;
      slot[3].ch = pad_chars.second;
    end else begin
      slot[0].ch = pad_chars.first;
      slot[1].ch = pad_chars.second;
      slot[2].ch = pad_chars.first;
      slot[3].ch = pad_chars.second;
    end
    if (pair_en && pad_en) begin
      slot[3].last = 1'b1;
      slot[3].done = end_r;
    end else begin
      slot[1].last = 1'b1;
      slot[1].done = end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      held_v_r <= 1'b0;
      rd_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (fire) begin
        held_r   <= held_nxt;
        held_v_r <= held_v_nxt;
      end
      if (fire && (n_res != '0)) begin
        rd_r  <= '0;
        cnt_r <= n_res;
      end else if (out_fire) begin
        rd_r  <= rd_r + 1'b1;
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (n_res != '0)) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        buf_r[i] <= slot[i];
      end
    end
  end

  // Output port.
  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.cipher_char = buf_r[rd_r].ch;
  assign out_ch.run_last    = buf_r[rd_r].last;
  assign out_ch.text_done   = buf_r[rd_r].done;

endmodule

[rtl/plf_pair.sv]
// Digraph encipher: locates two letters in the key square and applies the Playfair rules.
module plf_pair
  import plf_pkg::*;
(
  input  key_sq_t     key_sq,
  input  letter_t     letter_a,
  input  letter_t     letter_b,
  output pair_chars_t chars
);

  // Letter code stored at a square position.
  function automatic letter_t cell_at(key_sq_t sq, sq_idx_t r, sq_idx_t c);
    return sq[r][CODE_W*c +: CODE_W];
  endfunction

  // First match in row-major order; a missing letter sits at row 0, column 0.
  function automatic sq_pos_t locate(key_sq_t sq, letter_t code);
    sq_pos_t p;
    p = '0;
    for (int r = SQ_DIM - 1; r >= 0; r--) begin
      for (int c = SQ_DIM - 1; c >= 0; c--) begin
        if (cell_at(sq, sq_idx_t'(r), sq_idx_t'(c)) == code) begin
          p.row = sq_idx_t'(r);
          p.col = sq_idx_t'(c);
        end
      end
    end
    return p;
  endfunction

  // Step one place along a row or column with wrap.
  function automatic sq_idx_t wrap_inc(sq_idx_t v);
    return (v == sq_idx_t'(SQ_DIM - 1)) ? '0 : sq_idx_t'(v + 1'b1);
  endfunction

  sq_pos_t pos_a;
  sq_pos_t pos_b;
  letter_t out_a;
  letter_t out_b;

  assign pos_a = locate(key_sq, letter_a);
  assign pos_b = locate(key_sq, letter_b);

  // Same row, same column, or rectangle corners.
  always_comb begin
    if (pos_a.row == pos_b.row) begin
      out_a = cell_at(key_sq, pos_a.row, wrap_inc(pos_a.col));
      out_b = cell_at(key_sq, pos_b.row, wrap_inc(pos_b.col));
    end else if (pos_a.col == pos_b.col) begin
      out_a = cell_at(key_sq, wrap_inc(pos_a.row), pos_a.col);
      out_b = cell_at(key_sq, wrap_inc(pos_b.row), pos_b.col);
    end else begin
      out_a = cell_at(key_sq, pos_a.row, pos_b.col);
      out_b = cell_at(key_sq, pos_b.row, pos_a.col);
    end
  end

  assign chars.first  = to_char(out_a);
  assign chars.second = to_char(out_b);

endmodule
